### sv/ahpc_pkg.sv
`default_nettype none
package ahpc_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic CSR_MAX_AGE     = 1'b0;
   localparam logic CSR_MAX_ENTRIES = 1'b1;

   localparam int EVICT_BOUND = 512;

   typedef struct packed {
      logic        family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [15:0] port;
      logic [31:0] seen;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_op_type;

   // expired when now precedes seen or is more than max_age past it
   function automatic logic aged_out(input logic [31:0] seen, input logic [31:0] now,
                                     input logic [31:0] max_age);
      logic [31:0] diff;
      diff = now - seen;
      return (now < seen) || (diff > max_age);
   endfunction

endpackage
`default_nettype wire

### sv/ahpc_if.sv
`default_nettype none
interface ahpc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic        addr_family;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic [15:0] port;
   logic [31:0] current_time;
   modport source (output valid, func, addr_family, addr_high, addr_low, port, current_time,
                   input ready);
   modport sink (input valid, func, addr_family, addr_high, addr_low, port, current_time,
                 output ready);
endinterface

interface ahpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] seen_time;
   logic [8:0]  entry_count;
   modport source (output valid, found, seen_time, entry_count, input ready);
   modport sink (input valid, found, seen_time, entry_count, output ready);
endinterface

interface ahpc_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/ahpc_cell.sv
`default_nettype none
module ahpc_cell #(
   parameter int CW  = 9,
   parameter int IDX = 0
) (
   input  wire                       clock,
   input  wire ahpc_pkg::entry_type   key,
   input  wire ahpc_pkg::entry_type   nbr,
   input  wire ahpc_pkg::cell_op_type op,
   input  wire                       drop,
   input  wire [CW-1:0]              occ,
   output ahpc_pkg::entry_type       q,
   output logic                      match
);
   ahpc_pkg::entry_type data_ff;
   logic                match_ff;
   logic                here_valid;

   assign here_valid = CW'(IDX) < occ;

   always_ff @(posedge clock) begin
      if (op.shift && drop) begin
         data_ff <= nbr;
      end else if (op.write && (CW'(IDX) == occ)) begin
         data_ff <= key;
      end
      match_ff <= here_valid && data_ff.family == key.family &&
                  data_ff.addr_high == key.addr_high &&
                  data_ff.addr_low == key.addr_low && data_ff.port == key.port;
   end

   assign q     = data_ff;
   assign match = match_ff;
endmodule
`default_nettype wire

### sv/aging_host_port_cache_top.sv
`default_nettype none
// ordered address:port cache with expiry, built as a row of entry cells
// req_ch carries one operation per item: insert/refresh, lookup or remove of a key,
// with the present time. rsp_ch returns one item per request: found, seen_time and
// the entry count after the operation. csr_ch writes max_age (index 0) and
// max_entries (index 1); it is always ready. the user must see that it is written only
// while idle; the block itself does not enforce this. cells hold entries oldest first;
// every cell compares the key in parallel and a drop shifts all cells above the match
// one place toward the head together. a lookup, remove or invalid or unused request
// passes the match, act and resp states; an insert passes match, act, append, evict
// (repeated for each eviction over the limit; evictions only happen after max_entries
// was lowered, up to the count held), age and resp. the next item is accepted once
// the previous result is registered, so no new item is taken while one is running.
// reset empties the table and restores max_age 3600, max_entries 256; the slot
// contents are not cleared. while rsp_ch stalls the result register holds, one
// further item may be accepted and runs until its own result is ready.
module aging_host_port_cache_top #(
   parameter int CAPACITY = 256
) (
   input  wire clock,
   input  wire reset,
   ahpc_req_if.sink   req_ch,
   ahpc_rsp_if.source rsp_ch,
   ahpc_csr_if.sink   csr_ch
);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LV = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MATCH, ST_ACT, ST_APPEND, ST_EVICT, ST_AGE, ST_RESP
   } state_type;

   state_type            state_ff;
   logic [CW-1:0]        occ_ff;
   logic [31:0]          max_age_ff;
   logic [8:0]           max_entries_ff;
   ahpc_pkg::entry_type  key_ff;
   logic [1:0]           func_ff;
   logic                 valid_req_ff;
   logic [9:0]           removed_ff;
   logic                 found_ff;
   logic [31:0]          seen_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [31:0]          rsp_seen_ff;
   logic [8:0]           rsp_count_ff;

   ahpc_pkg::entry_type  cell_q [CAPACITY];
   logic [CAPACITY-1:0]  match_vec;
   logic [CAPACITY-1:0]  pfx [LV+1];
   logic [CAPACITY-1:0]  drop_vec;
   ahpc_pkg::cell_op_type op;
   logic                 drop_head;
   logic                 hit;
   logic [31:0]          seen_sel;
   logic [CW-1:0]        limit;
   logic                 sel_aged;
   logic                 head_aged;
   logic                 fam_in;
   logic [63:0]          hi_in;
   logic [63:0]          lo_in;

   assign fam_in = req_ch.addr_family;
   assign hi_in  = fam_in ? req_ch.addr_high : 64'd0;
   assign lo_in  = fam_in ? req_ch.addr_low : {32'd0, req_ch.addr_low[31:0]};

   assign limit = ({23'd0, max_entries_ff} > 32'(CAPACITY)) ? CAP_W : CW'(max_entries_ff);

   // prefix or of the match marks every cell at or above the hit
   always_comb begin
      pfx[0] = match_vec;
      for (int l = 0; l < LV; l++) begin
         pfx[l+1] = pfx[l] | (pfx[l] << (1 << l));
      end
   end

   always_comb begin
      seen_sel = 32'd0;
      for (int i = 0; i < CAPACITY; i++) begin
         seen_sel = seen_sel | ({32{match_vec[i]}} & cell_q[i].seen);
      end
   end

   assign hit       = |match_vec;
   assign sel_aged  = ahpc_pkg::aged_out(seen_sel, key_ff.seen, max_age_ff);
   assign head_aged = ahpc_pkg::aged_out(cell_q[0].seen, key_ff.seen, max_age_ff);
   assign drop_vec  = drop_head ? {CAPACITY{1'b1}} : pfx[LV];

   always_comb begin
      op        = '0;
      drop_head = 1'b0;
      case (state_ff)
         ST_ACT: begin
            if (valid_req_ff) begin
               case (func_ff)
                  ahpc_pkg::FUNC_INSERT: begin
                     if (hit) begin
                        op.shift = 1'b1;
                     end else if (occ_ff == CAP_W) begin
                        op.shift  = 1'b1;
                        drop_head = 1'b1;
                     end
                  end
                  ahpc_pkg::FUNC_LOOKUP: op.shift = hit && sel_aged;
                  ahpc_pkg::FUNC_REMOVE: op.shift = hit;
                  default: op = '0;
               endcase
            end
         end
         ST_APPEND: op.write = occ_ff < CAP_W;
         ST_EVICT: begin
            op.shift  = (occ_ff > limit) && (32'(removed_ff) < ahpc_pkg::EVICT_BOUND);
            drop_head = 1'b1;
         end
         ST_AGE: begin
            op.shift  = (occ_ff != '0) && head_aged;
            drop_head = 1'b1;
         end
         default: op = '0;
      endcase
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ahpc_pkg::entry_type nbr;
      if (g == CAPACITY - 1) begin : g_last
         assign nbr = cell_q[g];
      end else begin : g_mid
         assign nbr = cell_q[g+1];
      end
      ahpc_cell #(.CW(CW), .IDX(g)) u_cell (
         .clock (clock),
         .key   (key_ff),
         .nbr   (nbr),
         .op    (op),
         .drop  (drop_vec[g]),
         .occ   (occ_ff),
         .q     (cell_q[g]),
         .match (match_vec[g])
      );
   end

   assign req_ch.ready       = state_ff == ST_IDLE;
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.seen_time   = rsp_seen_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         occ_ff         <= '0;
         max_age_ff     <= 32'd3600;
         max_entries_ff <= 9'd256;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            if (csr_ch.index == ahpc_pkg::CSR_MAX_AGE) begin
               max_age_ff <= csr_ch.data;
            end else begin
               max_entries_ff <= csr_ch.data[8:0];
            end
         end
         // in the response state the handoff below owns the valid flag
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         if (op.shift) begin
            occ_ff <= occ_ff - 1'b1;
         end else if (op.write) begin
            occ_ff <= occ_ff + 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  key_ff       <= '{fam_in, hi_in, lo_in, req_ch.port, req_ch.current_time};
                  func_ff      <= req_ch.func;
                  valid_req_ff <= (req_ch.port != 16'd0) && ((hi_in | lo_in) != 64'd0);
                  found_ff     <= 1'b0;
                  seen_ff      <= 32'd0;
                  removed_ff   <= '0;
                  state_ff     <= ST_MATCH;
               end
            end
            ST_MATCH: state_ff <= ST_ACT;
            ST_ACT: begin
               if (valid_req_ff && func_ff == ahpc_pkg::FUNC_INSERT) begin
                  if (!hit && occ_ff == CAP_W) begin
                     removed_ff <= 10'd1;
                  end
                  state_ff <= ST_APPEND;
               end else begin
                  if (valid_req_ff && hit && func_ff == ahpc_pkg::FUNC_LOOKUP && !sel_aged) begin
                     found_ff <= 1'b1;
                     seen_ff  <= seen_sel;
                  end
                  if (valid_req_ff && hit && func_ff == ahpc_pkg::FUNC_REMOVE) begin
                     found_ff <= 1'b1;
                  end
                  state_ff <= ST_RESP;
               end
            end
            ST_APPEND: state_ff <= ST_EVICT;
            ST_EVICT: begin
               if (op.shift) begin
                  removed_ff <= removed_ff + 1'b1;
               end else begin
                  state_ff <= ST_AGE;
               end
            end
            ST_AGE: state_ff <= ST_RESP;
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_seen_ff  <= seen_ff;
                  rsp_count_ff <= 9'(occ_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset) occ_ff <= CAP_W)
      else $error("occupancy above capacity");
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACT |-> $onehot0(match_vec))
      else $error("key held in more than one cell");
   a_limit_met: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AGE |-> occ_ff <= limit)
      else $error("eviction left count above limit");
   a_drop_nonempty: assert property (@(posedge clock) disable iff (reset)
      op.shift |-> occ_ff != '0)
      else $error("drop from empty table");
endmodule
`default_nettype wire

### dv/ahpc_tb_if.sv
`default_nettype none
package ahpc_tb_pkg;
   // func code that the block ignores
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic        family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [15:0] port;
      logic [31:0] now;
   } req_item_type;

   typedef struct packed {
      logic        found;
      logic [31:0] seen_time;
      logic [8:0]  entry_count;
   } rsp_item_type;
endpackage
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ahpc_req_if req_ch();
   ahpc_rsp_if rsp_ch();
   ahpc_csr_if csr_ch();

   aging_host_port_cache_top #(.CAPACITY(CAP)) u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   ahpc_pkg::entry_type cache_tbl[CAP];
   int unsigned cache_cnt;
   logic [31:0] age_limit;
   logic [8:0]  entry_limit;

   ahpc_tb_pkg::req_item_type pending_reqs[$];
   ahpc_tb_pkg::rsp_item_type expected_rsps[$];
   int        err_count = 0;
   int        accepted = 0;
   bit        hold_req = 1'b0;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      err_count++;
   endtask

   function automatic bit is_expired(input logic [31:0] seen, input logic [31:0] now);
      longint d;
      d = longint'(now) - longint'(seen);
      return d < 0 || d > longint'(age_limit);
   endfunction

   function automatic void drop_entry(input int unsigned pos);
      if (pos >= cache_cnt) return;
      for (int unsigned i = pos; i + 1 < cache_cnt; i++) cache_tbl[i] = cache_tbl[i + 1];
      cache_cnt--;
   endfunction

   function automatic int find_entry(input ahpc_pkg::entry_type k);
      for (int i = 0; i < cache_cnt; i++)
         if (cache_tbl[i].family == k.family && cache_tbl[i].addr_high == k.addr_high &&
             cache_tbl[i].addr_low == k.addr_low && cache_tbl[i].port == k.port)
            return i;
      return -1;
   endfunction

   function automatic ahpc_tb_pkg::rsp_item_type predict_cache(
      input ahpc_tb_pkg::req_item_type r);
      ahpc_tb_pkg::rsp_item_type o;
      ahpc_pkg::entry_type       k;
      int          pos;
      int unsigned lim, evicted;
      o = '0;
      k.family = r.family;
      k.addr_high = r.family ? r.addr_high : 64'd0;
      k.addr_low = r.family ? r.addr_low : {32'd0, r.addr_low[31:0]};
      k.port = r.port;
      k.seen = r.now;
      if (r.port != 0 && (k.addr_high | k.addr_low) != 0) begin
         pos = find_entry(k);
         case (r.func)
            ahpc_pkg::FUNC_INSERT: begin
               lim = entry_limit > CAP ? CAP : entry_limit;
               evicted = 0;
               if (pos >= 0) drop_entry(pos);
               else if (cache_cnt >= CAP) begin
                  drop_entry(0);
                  evicted++;
               end
               if (cache_cnt < CAP) begin
                  cache_tbl[cache_cnt] = k;
                  cache_cnt++;
               end
               while (cache_cnt > lim && evicted < ahpc_pkg::EVICT_BOUND) begin
                  drop_entry(0);
                  evicted++;
               end
               if (cache_cnt > 0 && is_expired(cache_tbl[0].seen, r.now)) drop_entry(0);
            end
            ahpc_pkg::FUNC_LOOKUP: if (pos >= 0) begin
               if (is_expired(cache_tbl[pos].seen, r.now)) drop_entry(pos);
               else begin
                  o.found = 1'b1;
                  o.seen_time = cache_tbl[pos].seen;
               end
            end
            ahpc_pkg::FUNC_REMOVE: if (pos >= 0) begin
               drop_entry(pos);
               o.found = 1'b1;
            end
            default: ;
         endcase
      end
      o.entry_count = cache_cnt[8:0];
      return o;
   endfunction

   // driver: bursts with gaps
   int burst_left = 0;
   int gap_left = 0;
   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.addr_family = 1'b0;
      req_ch.addr_high = '0;
      req_ch.addr_low = '0;
      req_ch.port = '0;
      req_ch.current_time = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = ahpc_pkg::CSR_MAX_AGE;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            expected_rsps.push_back(predict_cache({req_ch.func, req_ch.addr_family,
               req_ch.addr_high, req_ch.addr_low, req_ch.port, req_ch.current_time}));
            accepted++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() != 0 && !hold_req) begin
            ahpc_tb_pkg::req_item_type r;
            r = pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.func <= r.func;
            req_ch.addr_family <= r.family;
            req_ch.addr_high <= r.addr_high;
            req_ch.addr_low <= r.addr_low;
            req_ch.port <= r.port;
            req_ch.current_time <= r.now;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end
         end else req_ch.valid <= 1'b0;
      end
   end

   // monitor and receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) report("result with nothing expected");
            else begin
               ahpc_tb_pkg::rsp_item_type e;
               e = expected_rsps.pop_front();
               if (rsp_ch.found !== e.found)
                  report($sformatf("found %0b want %0b", rsp_ch.found, e.found));
               if (rsp_ch.seen_time !== e.seen_time)
                  report($sformatf("seen_time %0d want %0d", rsp_ch.seen_time, e.seen_time));
               if (rsp_ch.entry_count !== e.entry_count)
                  report($sformatf("entry_count %0d want %0d",
                                   rsp_ch.entry_count, e.entry_count));
            end
         end
         stall_phase = (stall_phase + 1) % 64;
         // steady flow in the first quarter of the pattern, random stalls elsewhere
         rsp_ch.ready <= (stall_phase < 16) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   task automatic write_reg(input logic idx, input logic [31:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == ahpc_pkg::CSR_MAX_AGE) age_limit = val;
      else entry_limit = val[8:0];
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (CAP + 40) @(posedge clock);
   endtask

   // small key pool so that refreshes, hits and removes are common
   function automatic ahpc_tb_pkg::req_item_type rand_req(input logic [31:0] now,
                                                          input int pool);
      ahpc_tb_pkg::req_item_type r;
      int kid;
      kid = $urandom_range(0, pool);
      r.func = ($urandom_range(0, 40) == 0) ? ahpc_tb_pkg::FUNC_UNUSED :
               2'($urandom_range(0, 2));
      r.family = kid[0];
      r.addr_high = kid[0] ? {$urandom, $urandom} & 64'hF : {$urandom, $urandom};
      r.addr_low = {$urandom, 28'd0, 4'(kid >> 1)} ^ (kid[0] ? 64'd0 : {$urandom, 32'd0});
      r.port = 16'(1 + (kid % 3));
      if ($urandom_range(0, 30) == 0) r.port = 16'(0);
      if ($urandom_range(0, 40) == 0) begin
         r.addr_high = {$urandom, $urandom};
         r.addr_low = {$urandom, $urandom};
         r.port = 16'($urandom);
      end
      if ($urandom_range(0, 40) == 0) begin
         r.addr_high = '0;
         r.addr_low = '0;
      end
      r.now = now;
      return r;
   endfunction

   function automatic ahpc_tb_pkg::req_item_type mk(input logic [1:0] f, input logic fam,
      input logic [63:0] hi, input logic [63:0] lo, input logic [15:0] p,
      input logic [31:0] t);
      return {f, fam, hi, lo, p, t};
   endfunction

   initial begin
      logic [31:0] now;
      int n;
      age_limit = 32'd3600;
      entry_limit = 9'd256;
      cache_cnt = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b0, '1, 64'hFFFF_FFFF_0A00_0001,
                                16'hFFFF, 100));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_LOOKUP, 1'b0, '0, 64'h0A00_0001, 16'hFFFF, 100));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b1, '1, '1, 16'd1, 200));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_LOOKUP, 1'b1, '1, '1, 16'd1, 3800));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_LOOKUP, 1'b1, '1, '1, 16'd1, 3801));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b1, '0, '0, 16'd5, 10));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b0, '0, 64'd7, 16'd0, 10));
      pending_reqs.push_back(mk(ahpc_tb_pkg::FUNC_UNUSED, 1'b0, '0, 64'd7, 16'd5, 10));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b0, '0, 64'd7, 16'd5, 50));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_LOOKUP, 1'b0, '0, 64'd7, 16'd5, 40));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b0, '0, 64'd8, 16'd5, 0));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_REMOVE, 1'b0, '0, 64'd8, 16'd5, 0));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_REMOVE, 1'b0, '0, 64'd8, 16'd5, 0));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b0, '0, 64'd9, 16'd5,
                                32'hFFFF_FFFF));
      wait_idle();

      // fill past capacity so the full-table eviction shows up
      write_reg(ahpc_pkg::CSR_MAX_AGE, 32'hFFFF_FFFF);
      for (int i = 0; i < CAP + 4; i++)
         pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b1, 64'(i), 64'(i + 1), 16'd9,
                                   32'd1000));
      wait_idle();
      // lower limit to zero: mass eviction, then every new key goes at once
      write_reg(ahpc_pkg::CSR_MAX_ENTRIES, 32'd0);
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_INSERT, 1'b0, '0, 64'd3, 16'd3, 32'd1000));
      pending_reqs.push_back(mk(ahpc_pkg::FUNC_LOOKUP, 1'b0, '0, 64'd3, 16'd3, 32'd1000));
      wait_idle();

      // random phases through several register settings
      now = 32'd5000;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(ahpc_pkg::CSR_MAX_AGE, 32'd0);
               write_reg(ahpc_pkg::CSR_MAX_ENTRIES, 32'd511);
            end
            1: begin
               write_reg(ahpc_pkg::CSR_MAX_AGE, 32'd40);
               write_reg(ahpc_pkg::CSR_MAX_ENTRIES, 32'd8);
            end
            2: begin
               write_reg(ahpc_pkg::CSR_MAX_AGE, 32'd3600);
               write_reg(ahpc_pkg::CSR_MAX_ENTRIES, 32'd256);
            end
            3: begin
               write_reg(ahpc_pkg::CSR_MAX_AGE, 32'($urandom));
               write_reg(ahpc_pkg::CSR_MAX_ENTRIES, 32'd1);
            end
            4: write_reg(ahpc_pkg::CSR_MAX_ENTRIES, 32'($urandom_range(2, 300)));
            default: write_reg(ahpc_pkg::CSR_MAX_AGE, 32'd20);
         endcase
         n = 0;
         while (n < 262) begin
            now += $urandom_range(0, 4);
            if ($urandom_range(0, 50) == 0) now = $urandom;
            pending_reqs.push_back(rand_req(now, (ph == 2) ? 400 : 30));
            n++;
            if (ph == 3 && n == 150) begin
               // let everything drain before going on
               while (pending_reqs.size() != 0) @(posedge clock);
               hold_req = 1'b1;
               while (req_ch.valid || expected_rsps.size() != 0) @(posedge clock);
               hold_req = 1'b0;
            end
         end
         wait_idle();
      end

      if (err_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule
`default_nettype wire
